// ----- rtl/stok_pkg.sv -----
// Shared types, character codes and helpers for the source tokenizer stream.
package stok_pkg;

  // Lexer modes; codes above the word mode cannot arise and act as idle.
  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_LINE       = 4'd2,
    MODE_BLOCK      = 4'd3,
    MODE_BLOCK_STAR = 4'd4,
    MODE_DQ         = 4'd5,
    MODE_DQ_ESC     = 4'd6,
    MODE_SQ         = 4'd7,
    MODE_SQ_ESC     = 4'd8,
    MODE_WORD       = 4'd9
  } lex_mode_t;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result buffer sizing: room for two new results while two are still queued.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // One input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_end;
  } res_t;

  // Results produced by one lexer step, res0 first.
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic has, input logic fin);
    res_t r;
    r.out_byte  = b;
    r.has_byte  = has;
    r.token_end = fin;
    return r;
  endfunction

endpackage

// ----- rtl/stok_in_if.sv -----
// Input channel carrying one source byte and the end-of-input flag.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source(output valid, output in_byte, output end_of_input, input ready);
  modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/stok_out_if.sv -----
// Result channel carrying one token byte with its flags.
interface stok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       token_end;

  modport source(output valid, output out_byte, output has_byte, output token_end,
                 input ready);
  modport sink(input valid, input out_byte, input has_byte, input token_end,
               output ready);
endinterface

// ----- rtl/stok_in_stage.sv -----
// Input register that holds one word until the lexer takes it.
module stok_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  stok_pkg::in_word_t in_word,
  output logic              in_ready,
  output logic              word_vld,
  output stok_pkg::in_word_t word,
  input  logic              take
);
  import stok_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  in_word_t word_r;

  // Accept a new word when empty or when the held one leaves this cycle.
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign word_vld = vld_r;
  assign word     = word_r;
endmodule

// ----- rtl/stok_lex.sv -----
// Lexer mode register and the single-step decode of one source byte.
module stok_lex (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  stok_pkg::in_word_t word,
  output stok_pkg::push_t    push
);
  import stok_pkg::*;

  lex_mode_t  mode_r;
  lex_mode_t  mode_nxt;
  logic [7:0] b;
  logic       eoi;
  logic       ws;

  assign b   = word.in_byte;
  assign eoi = word.end_of_input;
  assign ws  = is_ws(b);

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (eoi) begin
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          priority if (b == CH_SLASH) mode_nxt = MODE_LINE;
          else if (b == CH_STAR)      mode_nxt = MODE_BLOCK;
          else if (ws)                mode_nxt = MODE_IDLE;
          else                        mode_nxt = MODE_WORD;
        end
        MODE_LINE: begin
          if (b == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          priority if (b == CH_SLASH) mode_nxt = MODE_IDLE;
          else if (b != CH_STAR)      mode_nxt = MODE_BLOCK;
          else                        mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_DQ: begin
          priority if (b == CH_BSLASH) mode_nxt = MODE_DQ_ESC;
          else if (b == CH_DQUOTE)     mode_nxt = MODE_IDLE;
          else                         mode_nxt = MODE_DQ;
        end
        MODE_DQ_ESC: mode_nxt = MODE_DQ;
        MODE_SQ: begin
          priority if (b == CH_BSLASH) mode_nxt = MODE_SQ_ESC;
          else if (b == CH_SQUOTE)     mode_nxt = MODE_IDLE;
          else                         mode_nxt = MODE_SQ;
        end
        MODE_SQ_ESC: mode_nxt = MODE_SQ;
        MODE_WORD: begin
          if (ws) mode_nxt = MODE_IDLE;
        end
        default: begin
          // Between tokens: this byte may open a token.
          priority if (ws)                             mode_nxt = MODE_IDLE;
          else if (b == CH_SLASH)                      mode_nxt = MODE_SLASH;
          else if (b == CH_LBRACE || b == CH_RBRACE)   mode_nxt = MODE_IDLE;
          else if (b == CH_DQUOTE)                     mode_nxt = MODE_DQ;
          else if (b == CH_SQUOTE)                     mode_nxt = MODE_SQ;
          else                                         mode_nxt = MODE_WORD;
        end
      endcase
    end
  end

  // Results of this step.
  always_comb begin
    push = '0;
    if (eoi) begin
      unique case (mode_r)
        MODE_SLASH: begin
          push.num  = 2'd1;
          push.res0 = mk_res(CH_SLASH, 1'b1, 1'b1);
        end
        MODE_DQ, MODE_DQ_ESC, MODE_SQ, MODE_SQ_ESC, MODE_WORD: begin
          push.num  = 2'd1;
          push.res0 = mk_res(8'h00, 1'b0, 1'b1);
        end
        default: push.num = 2'd0;
      endcase
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          priority if (b == CH_SLASH || b == CH_STAR) begin
            push.num = 2'd0;
          end else if (ws) begin
            push.num  = 2'd1;
            push.res0 = mk_res(CH_SLASH, 1'b1, 1'b1);
          end else begin
            push.num  = 2'd2;
            push.res0 = mk_res(CH_SLASH, 1'b1, 1'b0);
            push.res1 = mk_res(b, 1'b1, 1'b0);
          end
        end
        MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR: push.num = 2'd0;
        MODE_DQ: begin
          push.num  = 2'd1;
          push.res0 = mk_res(b, 1'b1, b == CH_DQUOTE);
        end
        MODE_SQ: begin
          push.num  = 2'd1;
          push.res0 = mk_res(b, 1'b1, b == CH_SQUOTE);
        end
        MODE_DQ_ESC, MODE_SQ_ESC: begin
          push.num  = 2'd1;
          push.res0 = mk_res(b, 1'b1, 1'b0);
        end
        MODE_WORD: begin
          push.num  = 2'd1;
          push.res0 = ws ? mk_res(8'h00, 1'b0, 1'b1) : mk_res(b, 1'b1, 1'b0);
        end
        default: begin
          // A brace is a whole token; a slash is held; other non-space bytes open one.
          priority if (ws || b == CH_SLASH) begin
            push.num = 2'd0;
          end else if (b == CH_LBRACE || b == CH_RBRACE) begin
            push.num  = 2'd1;
            push.res0 = mk_res(b, 1'b1, 1'b1);
          end else begin
            push.num  = 2'd1;
            push.res0 = mk_res(b, 1'b1, 1'b0);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (fire) begin
      mode_r <= mode_nxt;
    end
  end

  // Only a held slash can release two results in one step.
  a_two_from_slash: assert property (@(posedge clk) disable iff (!rst_n)
    fire && push.num == 2'd2 |-> mode_r == MODE_SLASH)
    else $error("two results from a mode other than held slash");

  // End of input always returns the lexer to idle.
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eoi |=> mode_r == MODE_IDLE)
    else $error("lexer not idle after end of input");

  // A result without a byte is a token end with a zero byte.
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    fire && push.num != 2'd0 && !push.res0.has_byte |->
      push.res0.out_byte == 8'h00 && push.res0.token_end)
    else $error("empty result that does not close a token");
endmodule

// ----- rtl/stok_res_fifo.sv -----
// Small result queue that takes up to two results and sends one per cycle while the output is ready.
module stok_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en,
  input  stok_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  output stok_pkg::res_t  out_res,
  input  logic            out_ready
);
  import stok_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r;
  logic [RES_PTR_W-1:0] wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r;
  logic [RES_PTR_W-1:0] rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_CNT_W-1:0] cnt_nxt;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push    = push_en ? push.num : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage, written in order at the write pointer.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + RES_PTR_W'(1)] <= push.res1;
    end
  end

  // The fill count never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // Results are only pushed while there is room for two.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> room)
    else $error("push into a result queue without room");

  // The count follows pushes and pops exactly.
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + RES_CNT_W'($past(n_push)) - RES_CNT_W'($past(pop)))
    else $error("result queue count out of step");
endmodule

// ----- rtl/source_tokenizer_stream.sv -----
// A word passes the input register, the lexer and the result queue on its way
// out. Throughput: one input word per cycle while the queue has room for two;
// the output sends one result per cycle while ready, and a word that yields two
// results (a held slash, then a word byte) is absorbed by the four-entry queue.
// Reset: synchronous, active low; returns the lexer to idle between tokens and
// empties the input register and the result queue.
module source_tokenizer_stream (
  input  logic            clk,
  input  logic            rst_n,
  stok_in_if.sink         in_chan,
  stok_out_if.source      out_chan
);
  import stok_pkg::*;

  in_word_t in_word;
  in_word_t word;
  logic     word_vld;
  logic     in_rdy;
  logic     take;
  logic     room;
  push_t    push;
  res_t     out_res;
  logic     out_vld;

  assign in_word.in_byte      = in_chan.in_byte;
  assign in_word.end_of_input = in_chan.end_of_input;
  assign in_chan.ready        = in_rdy;

  // The held word moves through the lexer when the queue has room for two.
  assign take = word_vld && room;

  stok_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_word  (in_word),
    .in_ready (in_rdy),
    .word_vld (word_vld),
    .word     (word),
    .take     (take)
  );

  stok_lex u_lex (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .word  (word),
    .push  (push)
  );

  stok_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (take),
    .push      (push),
    .room      (room),
    .out_valid (out_vld),
    .out_res   (out_res),
    .out_ready (out_chan.ready)
  );

  assign out_chan.valid     = out_vld;
  assign out_chan.out_byte  = out_res.out_byte;
  assign out_chan.has_byte  = out_res.has_byte;
  assign out_chan.token_end = out_res.token_end;
endmodule
